@@ hdl/wphg_pkg.sv @@
// Shared types, constants and lookup tables of the waypoint heading guidance block.
`timescale 1ns / 1ps

package wphg_pkg;

	// Datapath widths
	localparam int CORDIC_W = 37;	// vector components incl. CORDIC growth
	localparam int MAC_W    = 34;	// products and their sums
	localparam int CFG_W    = 32;	// widest configuration register
	localparam int ANG_W    = 16;	// binary angle, 32768 = pi

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SPAWN_OFFSET   = 3'd0,
		REG_CLOSE_DISTANCE = 3'd1,
		REG_ROUTE_LENGTH   = 3'd2,
		REG_WAYPOINT_0     = 3'd3,
		REG_WAYPOINT_1     = 3'd4,
		REG_WAYPOINT_2     = 3'd5,
		REG_WAYPOINT_3     = 3'd6,
		REG_WAYPOINT_4     = 3'd7
	} cfg_reg_t;

	// Direction codes
	typedef enum logic [1:0] {
		DIR_FORWARD  = 2'd0,
		DIR_BACKWARD = 2'd1,
		DIR_LEFT     = 2'd2,
		DIR_RIGHT    = 2'd3
	} dir_t;

	// Angles
	localparam logic signed [ANG_W-1:0] ANG_QUARTER    = 16'sd16384;
	localparam logic signed [ANG_W-1:0] ANG_NEG_QUARTER = -16'sd16384;
	localparam logic signed [ANG_W-1:0] ANG_EIGHTH     = 16'sd8192;
	localparam logic signed [ANG_W-1:0] ANG_3EIGHTHS   = 16'sd24576;

	// 1.0 at Q28 for the yaw denominator
	localparam logic signed [CORDIC_W-1:0] YAW_ONE = CORDIC_W'(2**28);

	// round(atan(2^-i) * 32768 / pi)
	localparam logic [ANG_W-1:0] ATAN_LUT [16] = '{
		16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
		16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
	};

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] SPAWN_RESET = 32'hF000_F980;
	localparam logic [15:0]      CLOSE_RESET = 16'd512;
	localparam logic [2:0]       ROUTE_RESET = 3'd5;
	localparam logic [CFG_W-1:0] WP_RESET [5] = '{
		32'hF000_F980, 32'h0D00_F933, 32'h0D00_014D, 32'h1700_014D, 32'h1700_0500
	};

	// CORDIC request and response
	typedef struct packed {
		logic                        start;
		logic signed [CORDIC_W-1:0]  x;
		logic signed [CORDIC_W-1:0]  y;
	} cordic_req_t;

	typedef struct packed {
		logic             done;
		logic [ANG_W-1:0] angle;
	} cordic_rsp_t;

endpackage

@@ hdl/wphg_cordic.sv @@
// Iterative CORDIC vectoring unit: atan2(y, x) into a 16-bit binary angle.
`timescale 1ns / 1ps

module wphg_cordic #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wphg_pkg::cordic_req_t req,
	output wphg_pkg::cordic_rsp_t rsp
);

	localparam int W     = wphg_pkg::CORDIC_W;
	localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

	logic signed [W-1:0] x_q, y_q;
	logic [wphg_pkg::ANG_W-1:0] z_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q, done_q, zero_q;

	logic signed [W-1:0] x_ld, y_ld, xs, ys;
	logic [wphg_pkg::ANG_W-1:0] z_ld, step_ang;

	// quadrant fold: left half-plane is turned by +/-90 degrees first
	always_comb begin
		x_ld = req.x;
		y_ld = req.y;
		z_ld = '0;
		if (req.x < 0) begin
			if (req.y >= 0) begin
				x_ld = req.y;
				y_ld = -req.x;
				z_ld = wphg_pkg::ANG_QUARTER;
			end else begin
				x_ld = -req.y;
				y_ld = req.x;
				z_ld = wphg_pkg::ANG_NEG_QUARTER;
			end
		end
	end

	// one micro-rotation per cycle
	assign xs       = x_q >>> cnt_q;
	assign ys       = y_q >>> cnt_q;
	assign step_ang = wphg_pkg::ATAN_LUT[4'(cnt_q)];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// vector and angle accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= x_ld;
			y_q    <= y_ld;
			z_q    <= z_ld;
			zero_q <= (req.x == '0) && (req.y == '0);
		end else if (run_q) begin
			if (!y_q[W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.angle = zero_q ? '0 : z_q;

	// start only lands on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !run_q)
		else $error("cordic started while running");

	// done follows the last iteration
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(run_q))
		else $error("cordic done without a run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q <= LAST))
		else $error("cordic step counter out of range");

endmodule

@@ hdl/waypoint_heading_guidance_unit.sv @@
// Top level of the waypoint heading guidance block.
`timescale 1ns / 1ps

// Usage:
// Odometry items enter on the s_axis channel (position Q8.8, quaternion Q2.14).
// Each item yields exactly one result item on the m_axis channel: tracked
// waypoint, global position, target bearing, yaw, wrapped heading error,
// direction code, mission-done flag and waypoint index.
// Configuration (spawn offset, close distance, route length, waypoints) is
// written through cfg_we/cfg_addr/cfg_wdata; the user must write it only while the
// block is idle. The block itself does not enforce this.
// Timing: one item at a time. A result is loaded into the output register at
// the end of the item, and the next item can be taken only after that.
// The processing time is set by the single CORDIC unit, one micro-rotation per
// cycle, used for yaw and then for the bearing, plus the multiply steps on the
// shared 17x17 multiplier for the yaw terms and the squared distances.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and processes the next item, then holds it until the register
// frees up.
// Reset clears the tracked index and mission-done flag and loads the default
// route and offset; no result is pending after reset.

module waypoint_heading_guidance_unit #(
	parameter int MAX_WAYPOINTS = 5,
	parameter int CORDIC_STEPS  = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	// odometry in
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// pos_x[15:0], pos_y[31:16], quat_x[47:32], quat_y[63:48], quat_z[79:64], quat_w[95:80]
	input  logic [95:0]   s_axis_tdata,
	// guidance out
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// goal_x[15:0], goal_y[31:16], current_x[47:32], current_y[63:48],
	// target_heading[79:64], current_heading[95:80], heading_error[111:96],
	// direction[113:112], mission_done[114], waypoint_index[117:115], zero[119:118]
	output logic [119:0]  m_axis_tdata,
	// configuration
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_wdata
);

	localparam int W      = wphg_pkg::CORDIC_W;
	localparam int MW     = wphg_pkg::MAC_W;
	localparam int WP_IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MAC    = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_YAW    = 6'b001000,
		ST_BEAR   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		MS_NUM_A = 3'd0,	// qw*qz
		MS_NUM_B = 3'd1,	// + qx*qy
		MS_SQ_A  = 3'd2,	// qy*qy
		MS_SQ_B  = 3'd3,	// + qz*qz
		MS_DX    = 3'd4,	// dx*dx
		MS_DY    = 3'd5,	// + dy*dy
		MS_RAD   = 3'd6		// close_distance^2
	} mac_step_t;

	state_t    state_q;
	mac_step_t mac_step_q;

	// configuration registers
	logic [31:0] spawn_q;
	logic [15:0] close_q;
	logic [2:0]  route_q;
	logic [31:0] wp_q [MAX_WAYPOINTS];

	// tracking state
	logic [2:0] tracked_idx_q;
	logic       done_flag_q;

	// per-item working registers
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q, cx_q, cy_q;
	logic signed [MW-1:0] num_q, sq_q, d2_q, r2_q;
	logic [15:0] yaw_q, bear_q;

	// output register
	logic         m_valid_q;
	logic [119:0] m_data_q;

	// saturating 16-bit add
	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		if (s[16] != s[15])
			return s[16] ? 16'sh8000 : 16'sh7FFF;
		return s[15:0];
	endfunction

	// ---- input unpack ----
	logic signed [15:0] in_px, in_py;
	assign in_px = s_axis_tdata[15:0];
	assign in_py = s_axis_tdata[31:16];

	assign s_axis_tready = (state_q == ST_IDLE);

	// ---- waypoint read and offsets to the target ----
	logic [31:0] wp_rd;
	logic signed [15:0] tx, ty;
	logic signed [16:0] dx, dy;
	assign wp_rd = wp_q[tracked_idx_q[WP_IDX_W-1:0]];
	assign tx    = wp_rd[31:16];
	assign ty    = wp_rd[15:0];
	assign dx    = 17'(tx) - 17'(cx_q);
	assign dy    = 17'(ty) - 17'(cy_q);

	// ---- shared multiplier ----
	logic signed [16:0] mul_a, mul_b;
	logic signed [MW-1:0] prod;

	always_comb begin
		unique case (mac_step_q)
			MS_NUM_A: begin mul_a = 17'(qw_q); mul_b = 17'(qz_q); end
			MS_NUM_B: begin mul_a = 17'(qx_q); mul_b = 17'(qy_q); end
			MS_SQ_A:  begin mul_a = 17'(qy_q); mul_b = 17'(qy_q); end
			MS_SQ_B:  begin mul_a = 17'(qz_q); mul_b = 17'(qz_q); end
			MS_DX:    begin mul_a = dx; mul_b = dx; end
			MS_DY:    begin mul_a = dy; mul_b = dy; end
			MS_RAD:   begin mul_a = {1'b0, close_q}; mul_b = {1'b0, close_q}; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod = mul_a * mul_b;

	// ---- arrival decision ----
	logic [2:0] len_eff;
	logic       arrive, last_wp;

	always_comb begin
		if (route_q == 3'd0)
			len_eff = 3'd1;
		else if (route_q > 3'(MAX_WAYPOINTS))
			len_eff = 3'(MAX_WAYPOINTS);
		else
			len_eff = route_q;
	end

	assign arrive  = !done_flag_q && (d2_q < r2_q);
	assign last_wp = ({1'b0, tracked_idx_q} + 4'd1) >= {1'b0, len_eff};

	// ---- CORDIC unit, yaw then bearing ----
	wphg_pkg::cordic_req_t cordic_req;
	wphg_pkg::cordic_rsp_t cordic_rsp;

	always_comb begin
		cordic_req.start = (state_q == ST_DECIDE) ||
			((state_q == ST_YAW) && cordic_rsp.done);
		if (state_q == ST_DECIDE) begin
			cordic_req.y = W'(num_q) <<< 1;
			cordic_req.x = wphg_pkg::YAW_ONE - (W'(sq_q) <<< 1);
		end else begin
			cordic_req.y = W'(dy) <<< 16;
			cordic_req.x = W'(dx) <<< 16;
		end
	end

	wphg_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.rsp    (cordic_rsp)
	);

	// ---- heading error and direction ----
	logic signed [15:0] err;
	logic [1:0] dir;
	assign err = bear_q - yaw_q;

	always_comb begin
		priority if ((err > -wphg_pkg::ANG_EIGHTH) && (err < wphg_pkg::ANG_EIGHTH))
			dir = wphg_pkg::DIR_FORWARD;
		else if ((err >= -wphg_pkg::ANG_3EIGHTHS) && (err <= -wphg_pkg::ANG_EIGHTH))
			dir = wphg_pkg::DIR_RIGHT;
		else if ((err >= wphg_pkg::ANG_EIGHTH) && (err <= wphg_pkg::ANG_3EIGHTHS))
			dir = wphg_pkg::DIR_LEFT;
		else
			dir = wphg_pkg::DIR_BACKWARD;
	end

	logic out_free;
	assign out_free = !m_valid_q || m_axis_tready;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_q <= wphg_pkg::SPAWN_RESET;
			close_q <= wphg_pkg::CLOSE_RESET;
			route_q <= wphg_pkg::ROUTE_RESET;
			for (int i = 0; i < MAX_WAYPOINTS; i++)
				wp_q[i] <= wphg_pkg::WP_RESET[i];
		end else if (cfg_we) begin
			if (cfg_addr == wphg_pkg::REG_SPAWN_OFFSET)
				spawn_q <= cfg_wdata;
			if (cfg_addr == wphg_pkg::REG_CLOSE_DISTANCE)
				close_q <= cfg_wdata[15:0];
			if (cfg_addr == wphg_pkg::REG_ROUTE_LENGTH)
				route_q <= cfg_wdata[2:0];
			for (int i = 0; i < MAX_WAYPOINTS; i++)
				if (cfg_addr == 3'(int'(wphg_pkg::REG_WAYPOINT_0) + i))
					wp_q[i] <= cfg_wdata;
		end
	end

	// ---- sequencer and tracking state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mac_step_q    <= MS_NUM_A;
			tracked_idx_q <= '0;
			done_flag_q   <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			// result register: loaded at the end of an item, cleared once taken
			if ((state_q == ST_FINISH) && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q    <= ST_MAC;
						mac_step_q <= MS_NUM_A;
					end
				end
				ST_MAC: begin
					if (mac_step_q == MS_RAD)
						state_q <= ST_DECIDE;
					else
						mac_step_q <= mac_step_t'(mac_step_q + 3'd1);
				end
				ST_DECIDE: begin
					if (arrive) begin
						if (last_wp)
							done_flag_q <= 1'b1;
						else
							tracked_idx_q <= tracked_idx_q + 3'd1;
					end
					state_q <= ST_YAW;
				end
				ST_YAW: begin
					if (cordic_rsp.done)
						state_q <= ST_BEAR;
				end
				ST_BEAR: begin
					if (cordic_rsp.done)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		// capture item, apply spawn offset
		if (s_axis_tvalid && s_axis_tready) begin
			cx_q <= sat_add(in_px, spawn_q[31:16]);
			cy_q <= sat_add(in_py, spawn_q[15:0]);
			qx_q <= s_axis_tdata[47:32];
			qy_q <= s_axis_tdata[63:48];
			qz_q <= s_axis_tdata[79:64];
			qw_q <= s_axis_tdata[95:80];
		end
		// multiply-accumulate steps
		if (state_q == ST_MAC) begin
			unique case (mac_step_q)
				MS_NUM_A: num_q <= prod;
				MS_NUM_B: num_q <= num_q + prod;
				MS_SQ_A:  sq_q  <= prod;
				MS_SQ_B:  sq_q  <= sq_q + prod;
				MS_DX:    d2_q  <= prod;
				MS_DY:    d2_q  <= d2_q + prod;
				MS_RAD:   r2_q  <= prod;
				default: ;
			endcase
		end
		// angle results
		if ((state_q == ST_YAW) && cordic_rsp.done)
			yaw_q <= cordic_rsp.angle;
		if ((state_q == ST_BEAR) && cordic_rsp.done)
			bear_q <= cordic_rsp.angle;
		// result item
		if ((state_q == ST_FINISH) && out_free)
			m_data_q <= {2'b00, tracked_idx_q, done_flag_q, dir, err, yaw_q, bear_q,
				cy_q, cx_q, ty, tx};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// tracked waypoint always within the stored waypoints
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		tracked_idx_q < 3'(MAX_WAYPOINTS))
		else $error("tracked waypoint index out of range");

	// mission done latches
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(done_flag_q))
		else $error("mission done flag cleared");

	// an accepted item starts the multiply phase
	a_accept_to_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MAC))
		else $error("accepted item did not start processing");

	// a result only appears at the end of an item
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

endmodule
